[hdl/frt_pkg.sv]
// Shared constants, types and codes for the fragment reassembly tracker.
`default_nettype none

package frt_pkg;

  localparam int BUCKETS = 16;
  localparam int WAYS    = 4;
  localparam int NSLOTS  = BUCKETS * WAYS;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int ID_W         = 16;
  localparam int CONN_W       = 16;
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 32;
  localparam int ACT_W        = 4;
  localparam int ENTRY_SLOT_W = 6;

  localparam logic [SIZE_W-1:0] HDR_BYTES = SIZE_W'(24);

  // msg_id mod BUCKETS by reciprocal multiply; exact for all 16-bit ids
  localparam int     BKT_L     = $clog2(BUCKETS);
  localparam int     BKT_SHIFT = ID_W + BKT_L;
  localparam int     PROD_W    = ID_W + BKT_SHIFT;
  localparam longint BKT_MUL   = (longint'(1) << BKT_SHIFT) / BUCKETS + 1;

  localparam logic       OP_PACKET = 1'b0;
  localparam logic       OP_FLUSH  = 1'b1;
  localparam logic [1:0] KIND_CTRL = 2'd0;
  localparam logic [1:0] KIND_USER = 2'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_STALE   = 4'd0,
    ACT_HELD    = 4'd1,
    ACT_WHOLE   = 4'd2,
    ACT_REASM   = 4'd3,
    ACT_CTRL    = 4'd4,
    ACT_BADTYPE = 4'd5,
    ACT_FULL    = 4'd6,
    ACT_LENERR  = 4'd7,
    ACT_FLUSH   = 4'd8
  } frt_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_CHECK,
    ST_UPDATE
  } frt_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] total;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [SIZE_W-1:0] remaining;
    logic [ID_W-1:0]   msg_id;
  } frt_entry_t;

  localparam int ENTRY_W = $bits(frt_entry_t);
  localparam int ROW_W   = WAYS * ENTRY_W;

endpackage

`default_nettype wire

[hdl/frt_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data between reads
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/fragment_reassembly_tracker.sv]
// Top level of the fragment reassembly tracker: control, lookup and result register.
//
// Usage: one packet header item enters on s_axis_* and exactly one result item
// leaves on m_axis_* for it, in order. s_axis_tuser carries op and packet_kind,
// s_axis_tdata the header fields. m_axis_tuser carries the action code,
// m_axis_tdata the delivered message fields, msg_id and the table slot used.
// cfg_wr_en/cfg_wr_data write the peer connection number; the user must do so
// only while the block idles, as the block itself leaves this unenforced.
// Items are handled one at a time. Flush, control, bad type, stale and whole
// messages load the result register from the decide step. Fragments go through
// a bucket lookup: reduce msg_id to its bucket, read the bucket row (all WAYS
// entries) from the slot RAM, match and pick a free way, then update and write
// back; the result loads in the update step, after the decide, read and check
// steps, as the registered RAM read and the row read-modify-write require.
// Reset clears all slot valid bits (flip-flops) and the peer number at once;
// no clearing pass of the RAM is needed. When the receiver stalls, the result
// stays in the output register; a new item is accepted meanwhile, and its own
// result waits in its last step until the register is free.
`default_nettype none

module fragment_reassembly_tracker
  import frt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] packet_size, [47:32] conn_number, [63:48] msg_id,
  // [95:64] src_addr, [127:96] dst_addr, [159:128] total_size
  input  wire logic [159:0] s_axis_tdata,
  // [0] op, [2:1] packet_kind
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] out_src, [63:32] out_dst, [95:64] out_size, [111:96] out_msg_id,
  // [117:112] entry_slot, [119:118] zero
  output logic      [119:0] m_axis_tdata,
  // [3:0] action
  output logic      [3:0]   m_axis_tuser
);

  frt_state_t state, state_next;

  logic [CONN_W-1:0] peer_conn_number;

  // latched request
  logic              req_op;
  logic [1:0]        req_kind;
  logic [SIZE_W-1:0] req_size;
  logic [CONN_W-1:0] req_conn;
  logic [ID_W-1:0]   req_id;
  logic [ADDR_W-1:0] req_src;
  logic [ADDR_W-1:0] req_dst;
  logic [SIZE_W-1:0] req_total;

  // decide stage
  logic [SIZE_W-1:0] payload;
  logic              is_short, is_short_next;
  logic              over_total, over_total_next;
  logic [SIZE_W-1:0] head_rem, head_rem_next;
  logic [SIZE_W-1:0] payload_q;
  logic [PROD_W-1:0] quot_prod;
  logic [ID_W-1:0]   quot, quot_next;

  // read stage
  logic [ID_W-1:0]   rem_val;
  logic [BKT_W-1:0]  bucket_q, bucket_next;

  // check stage
  frt_entry_t [WAYS-1:0] rd_row, wr_row;
  logic                  hit_next, free_next;
  logic [WAY_W-1:0]      hit_way_next, free_way_next;
  logic                  hit_q, free_q;
  logic [WAY_W-1:0]      hit_way_q, free_way_q;
  frt_entry_t            ent_q;

  // update stage
  logic [SIZE_W-1:0] new_rem;

  logic [BUCKETS-1:0][WAYS-1:0] slot_valid;

  // RAM port
  logic             ram_wr_en, ram_rd_en;
  logic [ROW_W-1:0] ram_rd_data;

  // result and table control
  logic              out_free;
  logic              res_fire;
  frt_action_t       res_action;
  logic [ADDR_W-1:0] res_src, res_dst;
  logic [SIZE_W-1:0] res_size;
  logic [ID_W-1:0]   res_id;
  logic [ENTRY_SLOT_W-1:0] res_slot;
  logic              flush_fire, clr_fire, set_fire;
  logic [WAY_W-1:0]  clr_way;

  logic s_fire;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign payload   = req_size - HDR_BYTES;
  assign quot_prod = PROD_W'(req_id) * PROD_W'(BKT_MUL);
  assign rem_val   = req_id - ID_W'(int'(quot) * BUCKETS);
  assign rd_row    = ram_rd_data;
  assign new_rem   = ent_q.remaining - payload_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_conn_number <= '0;
    end else if (cfg_wr_en) begin
      peer_conn_number <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_op    <= s_axis_tuser[0];
      req_kind  <= s_axis_tuser[2:1];
      req_size  <= s_axis_tdata[31:0];
      req_conn  <= s_axis_tdata[47:32];
      req_id    <= s_axis_tdata[63:48];
      req_src   <= s_axis_tdata[95:64];
      req_dst   <= s_axis_tdata[127:96];
      req_total <= s_axis_tdata[159:128];
    end
    if (state == ST_DECIDE) begin
      is_short   <= is_short_next;
      over_total <= over_total_next;
      head_rem   <= head_rem_next;
      payload_q  <= payload;
      quot       <= quot_next;
    end
    if (state == ST_READ) begin
      bucket_q <= bucket_next;
    end
    if (state == ST_CHECK) begin
      hit_q      <= hit_next;
      hit_way_q  <= hit_way_next;
      free_q     <= free_next;
      free_way_q <= free_way_next;
      ent_q      <= rd_row[hit_way_next];
    end
  end

  always_comb begin
    is_short_next   = (req_size < HDR_BYTES);
    over_total_next = (payload > req_total);
    head_rem_next   = req_total - payload;
    quot_next       = quot_prod[BKT_SHIFT +: ID_W];
    bucket_next     = rem_val[BKT_W-1:0];
  end

  // match and free search over the ways of the bucket; lowest way wins
  always_comb begin
    hit_next      = 1'b0;
    hit_way_next  = '0;
    free_next     = 1'b0;
    free_way_next = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (slot_valid[bucket_q][w] && rd_row[w].msg_id == req_id) begin
        hit_next     = 1'b1;
        hit_way_next = WAY_W'(w);
      end
      if (!slot_valid[bucket_q][w]) begin
        free_next     = 1'b1;
        free_way_next = WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_next = state;
    res_fire   = 1'b0;
    res_action = ACT_STALE;
    res_src    = '0;
    res_dst    = '0;
    res_size   = '0;
    res_id     = req_id;
    res_slot   = '0;
    flush_fire = 1'b0;
    clr_fire   = 1'b0;
    set_fire   = 1'b0;
    clr_way    = hit_way_q;
    ram_rd_en  = 1'b0;
    ram_wr_en  = 1'b0;
    wr_row     = rd_row;

    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (req_op == OP_FLUSH) begin
          res_action = ACT_FLUSH;
          res_id     = '0;
        end else if (req_kind == KIND_CTRL) begin
          res_action = ACT_CTRL;
        end else if (req_kind != KIND_USER) begin
          res_action = ACT_BADTYPE;
        end else if (req_conn != peer_conn_number) begin
          res_action = ACT_STALE;
        end else if (!is_short_next && payload == req_total) begin
          res_action = ACT_WHOLE;
          res_src    = req_src;
          res_dst    = req_dst;
          res_size   = req_total;
        end
        if (req_op == OP_PACKET && req_kind == KIND_USER &&
            req_conn == peer_conn_number &&
            (is_short_next || payload != req_total)) begin
          state_next = ST_READ;
        end else if (out_free) begin
          res_fire   = 1'b1;
          flush_fire = (req_op == OP_FLUSH);
          state_next = ST_IDLE;
        end
      end

      ST_READ: begin
        ram_rd_en  = 1'b1;
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        state_next = ST_UPDATE;
      end

      ST_UPDATE: begin
        if (is_short) begin
          res_action = ACT_LENERR;
          if (hit_q) begin
            clr_fire = 1'b1;
            res_slot = ENTRY_SLOT_W'(int'(bucket_q) * WAYS + int'(hit_way_q));
          end
        end else if (!hit_q) begin
          if (over_total) begin
            res_action = ACT_LENERR;
          end else if (!free_q) begin
            res_action = ACT_FULL;
          end else begin
            res_action                  = ACT_HELD;
            res_slot = ENTRY_SLOT_W'(int'(bucket_q) * WAYS + int'(free_way_q));
            set_fire                    = 1'b1;
            ram_wr_en                   = 1'b1;
            wr_row[free_way_q].msg_id    = req_id;
            wr_row[free_way_q].remaining = head_rem;
            wr_row[free_way_q].src       = req_src;
            wr_row[free_way_q].dst       = req_dst;
            wr_row[free_way_q].total     = req_total;
          end
        end else begin
          res_slot = ENTRY_SLOT_W'(int'(bucket_q) * WAYS + int'(hit_way_q));
          if (payload_q > ent_q.remaining) begin
            res_action = ACT_LENERR;
            clr_fire   = 1'b1;
          end else if (new_rem == '0) begin
            res_action = ACT_REASM;
            res_src    = ent_q.src;
            res_dst    = ent_q.dst;
            res_size   = ent_q.total;
            clr_fire   = 1'b1;
          end else begin
            res_action                  = ACT_HELD;
            ram_wr_en                   = 1'b1;
            wr_row[hit_way_q].remaining = new_rem;
          end
        end
        // hold every side effect until the result register is free
        if (out_free) begin
          res_fire   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          clr_fire  = 1'b0;
          set_fire  = 1'b0;
          ram_wr_en = 1'b0;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (flush_fire) begin
      slot_valid <= '0;
    end else if (clr_fire) begin
      slot_valid[bucket_q][clr_way] <= 1'b0;
    end else if (set_fire) begin
      slot_valid[bucket_q][free_way_q] <= 1'b1;
    end
  end

  frt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (bucket_q),
    .wr_data (wr_row),
    .rd_en   (ram_rd_en),
    .rd_addr (bucket_next),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      m_axis_tuser <= res_action;
      m_axis_tdata <= {2'b00, res_slot, res_id, res_size, res_dst, res_src};
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> !ram_rd_en)
    else $error("slot RAM read and write in the same cycle");

  a_head_into_free_way: assert property (@(posedge clk) disable iff (rst)
    set_fire |-> !slot_valid[bucket_q][free_way_q] && !hit_q)
    else $error("head entry stored over a valid way");

  a_reasm_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res_action == ACT_REASM) |-> (hit_q && state == ST_UPDATE))
    else $error("reassembled delivery without a matching entry");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    flush_fire |=> (slot_valid == '0))
    else $error("flush left valid entries");

endmodule

`default_nettype wire
